FILE: rtl/pisa_pkg.sv
// Shared types, widths and register codes for the PID controller with
// integral separation and anti-windup. No dependencies.
package pisa_pkg;

	localparam int SAMPLE_WIDTH   = 16;
	localparam int GAIN_FRAC_BITS = 8;

	localparam int GAIN_W  = 16;
	localparam int LIMIT_W = 31;
	localparam int THR_W   = 17;
	localparam int DRIVE_W = 32;
	localparam int ACC_W   = LIMIT_W + 1;
	localparam int CFG_W   = LIMIT_W;
	localparam int REG_IDX_W = 3;

	localparam int ERR_W   = SAMPLE_WIDTH + 1;
	localparam int DIFF_W  = SAMPLE_WIDTH + 2;
	localparam int PPROD_W = GAIN_W + ERR_W;
	localparam int DPROD_W = GAIN_W + DIFF_W;
	localparam int P_W     = PPROD_W - GAIN_FRAC_BITS;
	localparam int D_W     = DPROD_W - GAIN_FRAC_BITS;
	localparam int I_W     = PPROD_W - GAIN_FRAC_BITS;
	localparam int AI_W    = ((ACC_W > I_W) ? ACC_W : I_W) + 1;
	localparam int SUM_MAXW = (P_W > ACC_W) ? ((P_W > D_W) ? P_W : D_W)
	                                        : ((ACC_W > D_W) ? ACC_W : D_W);
	localparam int SUM_W   = SUM_MAXW + 2;
	localparam int CMP_W   = (ERR_W > THR_W) ? ERR_W : THR_W;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_GAIN_P         = 3'd0,
		REG_GAIN_I         = 3'd1,
		REG_GAIN_D         = 3'd2,
		REG_OUTPUT_LIMIT   = 3'd3,
		REG_INTEGRAL_LIMIT = 3'd4,
		REG_SEP_THRESHOLD  = 3'd5
	} reg_idx_t;

	localparam logic CMD_STEP  = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

	typedef struct packed {
		logic signed [GAIN_W-1:0] gain_p;
		logic signed [GAIN_W-1:0] gain_i;
		logic signed [GAIN_W-1:0] gain_d;
		logic [LIMIT_W-1:0]       output_limit;
		logic [LIMIT_W-1:0]       integral_limit;
		logic [THR_W-1:0]         separation_threshold;
	} cfg_t;

	typedef struct packed {
		logic                           cmd;
		logic signed [SAMPLE_WIDTH-1:0] setpoint;
		logic signed [SAMPLE_WIDTH-1:0] measured;
	} in_item_t;

	typedef struct packed {
		logic signed [DRIVE_W-1:0] drive;
		logic                      output_clamped;
		logic                      integral_clamped;
	} out_item_t;

endpackage

FILE: rtl/pisa_in_if.sv
// Input channel: valid/ready handshake carrying one control command beat.
// Depends on pisa_pkg for the sample width.
interface pisa_in_if;
	logic                                     valid;
	logic                                     ready;
	logic                                     cmd;
	logic signed [pisa_pkg::SAMPLE_WIDTH-1:0] setpoint;
	logic signed [pisa_pkg::SAMPLE_WIDTH-1:0] measured;

	modport source (output valid, output cmd, output setpoint, output measured, input ready);
	modport sink   (input valid, input cmd, input setpoint, input measured, output ready);
endinterface

FILE: rtl/pisa_out_if.sv
// Output channel: valid/ready handshake carrying one drive result beat.
// Depends on pisa_pkg for the drive width.
interface pisa_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [pisa_pkg::DRIVE_W-1:0] drive;
	logic                                output_clamped;
	logic                                integral_clamped;

	modport source (output valid, output drive, output output_clamped,
	                output integral_clamped, input ready);
	modport sink   (input valid, input drive, input output_clamped,
	                input integral_clamped, output ready);
endinterface

FILE: rtl/pisa_cfg_regs.sv
// Configuration register bank: gains, limits and separation threshold.
// Depends on pisa_pkg for cfg_t and the register codes.
module pisa_cfg_regs (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pisa_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [pisa_pkg::CFG_W-1:0]      cfg_data,
	output pisa_pkg::cfg_t                  cfg
);

	pisa_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_p               <= '0;
			cfg_q.gain_i               <= '0;
			cfg_q.gain_d               <= '0;
			cfg_q.output_limit         <= '1;
			cfg_q.integral_limit       <= '1;
			cfg_q.separation_threshold <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				pisa_pkg::REG_GAIN_P: begin
					cfg_q.gain_p <= cfg_data[pisa_pkg::GAIN_W-1:0];
				end
				pisa_pkg::REG_GAIN_I: begin
					cfg_q.gain_i <= cfg_data[pisa_pkg::GAIN_W-1:0];
				end
				pisa_pkg::REG_GAIN_D: begin
					cfg_q.gain_d <= cfg_data[pisa_pkg::GAIN_W-1:0];
				end
				pisa_pkg::REG_OUTPUT_LIMIT: begin
					cfg_q.output_limit <= cfg_data[pisa_pkg::LIMIT_W-1:0];
				end
				pisa_pkg::REG_INTEGRAL_LIMIT: begin
					cfg_q.integral_limit <= cfg_data[pisa_pkg::LIMIT_W-1:0];
				end
				pisa_pkg::REG_SEP_THRESHOLD: begin
					cfg_q.separation_threshold <= cfg_data[pisa_pkg::THR_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: rtl/pisa_core.sv
// Control-law datapath: error, P/I/D products, integral update with
// separation and hold, clamps, plus the integral and last-error state.
// Depends on pisa_pkg for types and widths.
module pisa_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  pisa_pkg::in_item_t   item,
	input  pisa_pkg::cfg_t       cfg,
	output pisa_pkg::out_item_t  result
);

	localparam int ERR_W = pisa_pkg::ERR_W;
	localparam int ACC_W = pisa_pkg::ACC_W;
	localparam int AI_W  = pisa_pkg::AI_W;
	localparam int SUM_W = pisa_pkg::SUM_W;
	localparam int CMP_W = pisa_pkg::CMP_W;
	localparam int FRAC  = pisa_pkg::GAIN_FRAC_BITS;

	logic signed [ACC_W-1:0] acc_q;
	logic signed [ERR_W-1:0] prev_err_q;

	logic signed [ERR_W-1:0]              err;
	logic signed [pisa_pkg::DIFF_W-1:0]   diff;
	logic        [ERR_W-1:0]              err_abs;
	logic signed [pisa_pkg::PPROD_W-1:0]  p_prod;
	logic signed [pisa_pkg::PPROD_W-1:0]  i_prod;
	logic signed [pisa_pkg::DPROD_W-1:0]  d_prod;
	logic signed [pisa_pkg::P_W-1:0]      p_term;
	logic signed [pisa_pkg::I_W-1:0]      i_term;
	logic signed [pisa_pkg::D_W-1:0]      d_term;
	logic signed [ACC_W-1:0]              ilim;
	logic signed [ACC_W-1:0]              ilim_neg;
	logic signed [SUM_W-1:0]              olim;
	logic signed [SUM_W-1:0]              olim_neg;
	logic                                 integrate;
	logic                                 hold;
	logic signed [AI_W-1:0]               acc_sum;
	logic signed [ACC_W-1:0]              acc_upd;
	logic signed [ACC_W-1:0]              acc_next;
	logic signed [SUM_W-1:0]              sum;
	logic signed [SUM_W-1:0]              drive_full;
	logic                                 oclamp;
	logic                                 iclamp;

	assign err  = ERR_W'(item.setpoint) - ERR_W'(item.measured);
	assign diff = pisa_pkg::DIFF_W'(err) - pisa_pkg::DIFF_W'(prev_err_q);
	assign err_abs = err[ERR_W-1] ? ERR_W'(-err) : err;

	assign p_prod = pisa_pkg::PPROD_W'(cfg.gain_p) * pisa_pkg::PPROD_W'(err);
	assign i_prod = pisa_pkg::PPROD_W'(cfg.gain_i) * pisa_pkg::PPROD_W'(err);
	assign d_prod = pisa_pkg::DPROD_W'(cfg.gain_d) * pisa_pkg::DPROD_W'(diff);

	// dropping the fraction bits is a floor shift on two's complement
	assign p_term = p_prod[pisa_pkg::PPROD_W-1:FRAC];
	assign i_term = i_prod[pisa_pkg::PPROD_W-1:FRAC];
	assign d_term = d_prod[pisa_pkg::DPROD_W-1:FRAC];

	assign ilim     = ACC_W'(cfg.integral_limit);
	assign ilim_neg = -ilim;
	assign olim     = SUM_W'(cfg.output_limit);
	assign olim_neg = -olim;

	assign integrate = (cfg.separation_threshold == '0) ||
	                   (CMP_W'(err_abs) < CMP_W'(cfg.separation_threshold));

	// stop accumulating when already at a limit and the error pushes further
	assign hold = ((acc_q >= ilim) && !err[ERR_W-1] && (err != '0)) ||
	              ((acc_q <= ilim_neg) && err[ERR_W-1]);

	always_comb begin
		acc_sum = hold ? AI_W'(acc_q) : (AI_W'(acc_q) + AI_W'(i_term));
		if (acc_sum > AI_W'(ilim)) begin
			acc_upd = ilim;
		end else if (acc_sum < AI_W'(ilim_neg)) begin
			acc_upd = ilim_neg;
		end else begin
			acc_upd = acc_sum[ACC_W-1:0];
		end
		acc_next = integrate ? acc_upd : acc_q;
	end

	assign iclamp = (acc_next >= ilim) || (acc_next <= ilim_neg);

	always_comb begin
		sum = SUM_W'(p_term) + SUM_W'(acc_next) + SUM_W'(d_term);
		oclamp = 1'b0;
		drive_full = sum;
		if (sum > olim) begin
			drive_full = olim;
			oclamp = 1'b1;
		end else if (sum < olim_neg) begin
			drive_full = olim_neg;
			oclamp = 1'b1;
		end
	end

	always_comb begin
		if (item.cmd == pisa_pkg::CMD_CLEAR) begin
			result = '0;
		end else begin
			result.drive            = drive_full[pisa_pkg::DRIVE_W-1:0];
			result.output_clamped   = oclamp;
			result.integral_clamped = iclamp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q      <= '0;
			prev_err_q <= '0;
		end else if (fire) begin
			if (item.cmd == pisa_pkg::CMD_CLEAR) begin
				acc_q      <= '0;
				prev_err_q <= '0;
			end else begin
				acc_q      <= acc_next;
				prev_err_q <= err;
			end
		end
	end

endmodule

FILE: rtl/pid_integral_separation_antiwindup.sv
// Top level of the fixed-point PID controller with integral separation and
// anti-windup. Depends on pisa_pkg, pisa_in_if, pisa_out_if, pisa_cfg_regs, pisa_core.

// Throughput is one command beat per clock while the result channel is not
// stalled: the integral and last-error registers close their loop as each
// beat leaves the input register, so a new beat is taken every cycle while
// results keep draining. The command beat waits in the input register,
// during which the control law is evaluated, and the state and result
// register load when the beat advances; the result beat is then offered
// on the output channel. Backpressure on the result channel stalls the
// pipeline without losing beats. Configuration writes take effect on the
// next clock and should be made only while no beat is in flight. A clear
// command zeroes the integral and last error and returns a zero drive.
module pid_integral_separation_antiwindup (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [pisa_pkg::REG_IDX_W-1:0]  cfg_index,
	input  logic [pisa_pkg::CFG_W-1:0]      cfg_data,
	pisa_in_if.sink                         in_ch,
	pisa_out_if.source                      out_ch
);

	pisa_pkg::cfg_t      cfg;
	pisa_pkg::in_item_t  item_s1;
	logic                valid_s1;
	pisa_pkg::out_item_t result;
	pisa_pkg::out_item_t res_s2;
	logic                valid_s2;
	logic                advance;
	logic                fire;

	pisa_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pisa_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (fire),
		.item   (item_s1),
		.cfg    (cfg),
		.result (result)
	);

	// result register free or emptying this cycle
	assign advance     = !valid_s2 || out_ch.ready;
	assign fire        = valid_s1 && advance;
	assign in_ch.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.ready && in_ch.valid) begin
			item_s1.cmd      <= in_ch.cmd;
			item_s1.setpoint <= in_ch.setpoint;
			item_s1.measured <= in_ch.measured;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= result;
		end
	end

	assign out_ch.valid            = valid_s2;
	assign out_ch.drive            = res_s2.drive;
	assign out_ch.output_clamped   = res_s2.output_clamped;
	assign out_ch.integral_clamped = res_s2.integral_clamped;

endmodule
